>>> rtl/epcr_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and saturation helpers for the elastic pair collision block
package epcr_pkg;

   typedef struct packed {
      logic signed [31:0] push_x;
      logic signed [31:0] push_y;
      logic signed [31:0] push_z;
      logic [31:0]        mass_a;
      logic [31:0]        mass_b;
      logic signed [31:0] vel_a_x;
      logic signed [31:0] vel_a_y;
      logic signed [31:0] vel_a_z;
      logic signed [31:0] vel_b_x;
      logic signed [31:0] vel_b_y;
      logic signed [31:0] vel_b_z;
   } req_word_type;

   typedef struct packed {
      logic               which_body;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               zero_mass;
   } rsp_word_type;

   localparam logic BODY_A = 1'b0;
   localparam logic BODY_B = 1'b1;

   // sign and magnitude to a saturated 32-bit two's complement value
   function automatic logic [31:0] sat_sm(input logic neg, input logic [36:0] mag);
      logic [31:0] r;
      if (!neg) begin
         r = (mag > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         r = (mag > 37'h0_8000_0000) ? 32'h8000_0000 : 32'(~mag[31:0] + 32'd1);
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_s(input logic signed [36:0] v);
      logic [31:0] r;
      if (v > 37'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -37'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? 32'(~v + 32'd1) : v;
   endfunction

endpackage

>>> rtl/epcr_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the request and response words
interface epcr_req_if;
   logic                      valid;
   logic                      ready;
   epcr_pkg::req_word_type    data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface epcr_rsp_if;
   logic                      valid;
   logic                      ready;
   epcr_pkg::rsp_word_type    data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/elastic_pair_collision_response.sv
`timescale 1ns / 1ps
// Elastic collision response for one body pair: a 73-stage pipeline followed by a
// two-word output buffer. Each request word gives two response words, body A then
// body B, so the output port, which moves one word a cycle while ready is high, sets
// the pair rate; new pairs enter while earlier ones are still in the pipeline. The
// pipeline holds the 32 one-bit-per-stage steps of the push length square root (run
// alongside the 32-step mass weight divide) and the 31 steps of the contact direction
// divide. A zero push gives no response words. When both masses are zero both words
// carry the zero mass flag with no move and the input velocities. The pipeline advances
// as a whole and holds only while its last stage has words the buffer cannot take.
module elastic_pair_collision_response (
   input  logic       clock,
   input  logic       reset,
   epcr_req_if.sink   req_ch,
   epcr_rsp_if.source rsp_ch
);

   localparam int ST_SQR     = 1;
   localparam int ST_SUM     = 2;
   localparam int ST_ROOT0   = 3;
   localparam int ROOT_STEPS = 32;
   localparam int ST_UNIT0   = ST_ROOT0 + ROOT_STEPS;
   localparam int UNIT_STEPS = 31;
   localparam int ST_PROD    = ST_UNIT0 + UNIT_STEPS;
   localparam int ST_SUMS    = ST_PROD + 1;
   localparam int ST_CQ      = ST_PROD + 2;
   localparam int ST_DIFF    = ST_PROD + 3;
   localparam int ST_KMUL    = ST_PROD + 4;
   localparam int ST_TMUL    = ST_PROD + 5;
   localparam int ST_VEL     = ST_PROD + 6;
   localparam int N_STAGES   = ST_VEL + 1;

   typedef struct packed {
      logic              emit;
      logic              zero_mass;
      logic [2:0]        p_neg;
      logic [2:0][31:0]  p_mag;
      logic [2:0][31:0]  va;
      logic [2:0][31:0]  vb;
      logic [32:0]       total;
      logic [2:0][63:0]  sqr;
      logic [63:0]       sq_rem;
      logic [63:0]       root;
      logic [63:0]       fa_rem;
      logic [31:0]       fa;
      logic [2:0][61:0]  u_rem;
      logic [2:0][30:0]  u_mag;
      logic [2:0][63:0]  dpa;
      logic [2:0][63:0]  dpb;
      logic [2:0][63:0]  mva_prod;
      logic [2:0][63:0]  mvb_prod;
      logic [63:0]       da;
      logic [63:0]       db;
      logic [2:0][31:0]  move_a;
      logic [2:0][31:0]  move_b;
      logic [33:0]       ca;
      logic [33:0]       cb;
      logic [33:0]       d_mag;
      logic              d_neg;
      logic [35:0]       ka_mag;
      logic [35:0]       kb_mag;
      logic [2:0][34:0]  ta_mag;
      logic [2:0][34:0]  tb_mag;
      logic [2:0][31:0]  nva;
      logic [2:0][31:0]  nvb;
   } pipe_type;

   pipe_type              stg_ff [N_STAGES];
   pipe_type              stg_in [N_STAGES];
   logic [N_STAGES-1:0]   vld_ff;

   epcr_pkg::rsp_word_type buf_a_ff;
   epcr_pkg::rsp_word_type buf_b_ff;
   epcr_pkg::rsp_word_type load_a;
   epcr_pkg::rsp_word_type load_b;
   logic                   buf_vld_ff;
   logic                   sel_ff;
   logic                   buf_free;
   logic                   tail_live;
   logic                   adv;

   genvar g;
   generate
      for (g = 0; g < N_STAGES; g++) begin : g_stage
         if (g == 0) begin : g_entry
            always_comb begin
               stg_in[0] = '0;
               stg_in[0].emit = (req_ch.data.push_x != '0) || (req_ch.data.push_y != '0) ||
                                (req_ch.data.push_z != '0);
               stg_in[0].p_neg = {req_ch.data.push_z[31], req_ch.data.push_y[31],
                                  req_ch.data.push_x[31]};
               stg_in[0].p_mag[0] = epcr_pkg::mag32(req_ch.data.push_x);
               stg_in[0].p_mag[1] = epcr_pkg::mag32(req_ch.data.push_y);
               stg_in[0].p_mag[2] = epcr_pkg::mag32(req_ch.data.push_z);
               stg_in[0].va = {req_ch.data.vel_a_z, req_ch.data.vel_a_y, req_ch.data.vel_a_x};
               stg_in[0].vb = {req_ch.data.vel_b_z, req_ch.data.vel_b_y, req_ch.data.vel_b_x};
               stg_in[0].total = {1'b0, req_ch.data.mass_a} + {1'b0, req_ch.data.mass_b};
               stg_in[0].zero_mass = (stg_in[0].total == '0);
               stg_in[0].fa_rem = {1'b0, req_ch.data.mass_a, 31'b0};
               for (int i = 0; i < 3; i++) begin
                  stg_in[0].u_rem[i] = {stg_in[0].p_mag[i], 30'b0};
               end
            end
         end else if (g == ST_SQR) begin : g_sqr
            always_comb begin
               stg_in[g] = stg_ff[g-1];
               for (int i = 0; i < 3; i++) begin
                  stg_in[g].sqr[i] = 64'(stg_ff[g-1].p_mag[i]) * 64'(stg_ff[g-1].p_mag[i]);
               end
            end
         end else if (g == ST_SUM) begin : g_sum
            always_comb begin
               stg_in[g] = stg_ff[g-1];
               stg_in[g].sq_rem = stg_ff[g-1].sqr[0] + stg_ff[g-1].sqr[1] + stg_ff[g-1].sqr[2];
               stg_in[g].root = '0;
            end
         end else if (g < ST_UNIT0) begin : g_root
            localparam int K = g - ST_ROOT0;
            localparam int J = 31 - K;
            localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * K);
            always_comb begin
               logic [63:0] sq_try;
               logic [63:0] fa_try;
               stg_in[g] = stg_ff[g-1];
               // integer root, one result bit a stage
               sq_try = stg_ff[g-1].root + SQ_BIT;
               if (stg_ff[g-1].sq_rem >= sq_try) begin
                  stg_in[g].sq_rem = stg_ff[g-1].sq_rem - sq_try;
                  stg_in[g].root = (stg_ff[g-1].root >> 1) + SQ_BIT;
               end else begin
                  stg_in[g].root = stg_ff[g-1].root >> 1;
               end
               // mass weight quotient, one bit a stage
               fa_try = 64'(stg_ff[g-1].total) << J;
               if (stg_ff[g-1].fa_rem >= fa_try) begin
                  stg_in[g].fa_rem = stg_ff[g-1].fa_rem - fa_try;
                  stg_in[g].fa[J] = 1'b1;
               end
            end
         end else if (g < ST_PROD) begin : g_unit
            localparam int J = 30 - (g - ST_UNIT0);
            always_comb begin
               logic [61:0] u_try;
               stg_in[g] = stg_ff[g-1];
               u_try = 62'(stg_ff[g-1].root[31:0]) << J;
               for (int i = 0; i < 3; i++) begin
                  if (stg_ff[g-1].u_rem[i] >= u_try) begin
                     stg_in[g].u_rem[i] = stg_ff[g-1].u_rem[i] - u_try;
                     stg_in[g].u_mag[i][J] = 1'b1;
                  end
               end
            end
         end else if (g == ST_PROD) begin : g_prod
            always_comb begin
               logic [31:0]        fb;
               logic signed [31:0] u_s;
               stg_in[g] = stg_ff[g-1];
               fb = 32'h8000_0000 - stg_ff[g-1].fa;
               for (int i = 0; i < 3; i++) begin
                  u_s = stg_ff[g-1].p_neg[i] ? -$signed({1'b0, stg_ff[g-1].u_mag[i]})
                                             : $signed({1'b0, stg_ff[g-1].u_mag[i]});
                  stg_in[g].dpa[i] = 64'(64'(u_s) * 64'($signed(stg_ff[g-1].va[i])));
                  stg_in[g].dpb[i] = 64'(64'(u_s) * 64'($signed(stg_ff[g-1].vb[i])));
                  stg_in[g].mva_prod[i] = 64'(stg_ff[g-1].p_mag[i]) * 64'(fb);
                  stg_in[g].mvb_prod[i] = 64'(stg_ff[g-1].p_mag[i]) * 64'(stg_ff[g-1].fa);
               end
            end
         end else if (g == ST_SUMS) begin : g_sums
            always_comb begin
               stg_in[g] = stg_ff[g-1];
               stg_in[g].da = stg_ff[g-1].dpa[0] + stg_ff[g-1].dpa[1] + stg_ff[g-1].dpa[2];
               stg_in[g].db = stg_ff[g-1].dpb[0] + stg_ff[g-1].dpb[1] + stg_ff[g-1].dpb[2];
               // body A moves against the push, body B along it
               for (int i = 0; i < 3; i++) begin
                  stg_in[g].move_a[i] = epcr_pkg::sat_sm(~stg_ff[g-1].p_neg[i],
                                           37'(stg_ff[g-1].mva_prod[i][62:31]));
                  stg_in[g].move_b[i] = epcr_pkg::sat_sm(stg_ff[g-1].p_neg[i],
                                           37'(stg_ff[g-1].mvb_prod[i][62:31]));
               end
            end
         end else if (g == ST_CQ) begin : g_cq
            always_comb begin
               logic [63:0] a_adj;
               logic [63:0] b_adj;
               stg_in[g] = stg_ff[g-1];
               // divide by 2^30 rounding toward zero
               a_adj = stg_ff[g-1].da + (stg_ff[g-1].da[63] ? 64'h3FFF_FFFF : 64'd0);
               b_adj = stg_ff[g-1].db + (stg_ff[g-1].db[63] ? 64'h3FFF_FFFF : 64'd0);
               stg_in[g].ca = a_adj[63:30];
               stg_in[g].cb = b_adj[63:30];
            end
         end else if (g == ST_DIFF) begin : g_diff
            always_comb begin
               logic [34:0] diff;
               logic [34:0] dabs;
               stg_in[g] = stg_ff[g-1];
               diff = {stg_ff[g-1].cb[33], stg_ff[g-1].cb} - {stg_ff[g-1].ca[33], stg_ff[g-1].ca};
               dabs = diff[34] ? 35'(~diff + 35'd1) : diff;
               stg_in[g].d_neg = diff[34];
               stg_in[g].d_mag = dabs[33:0];
            end
         end else if (g == ST_KMUL) begin : g_kmul
            always_comb begin
               logic [31:0] fb;
               logic [65:0] pa;
               logic [65:0] pb;
               stg_in[g] = stg_ff[g-1];
               fb = 32'h8000_0000 - stg_ff[g-1].fa;
               pa = 66'(stg_ff[g-1].d_mag) * 66'(fb);
               pb = 66'(stg_ff[g-1].d_mag) * 66'(stg_ff[g-1].fa);
               stg_in[g].ka_mag = pa[65:30];
               stg_in[g].kb_mag = pb[65:30];
            end
         end else if (g == ST_TMUL) begin : g_tmul
            always_comb begin
               logic [66:0] pa;
               logic [66:0] pb;
               stg_in[g] = stg_ff[g-1];
               for (int i = 0; i < 3; i++) begin
                  pa = 67'(stg_ff[g-1].ka_mag) * 67'(stg_ff[g-1].u_mag[i]);
                  pb = 67'(stg_ff[g-1].kb_mag) * 67'(stg_ff[g-1].u_mag[i]);
                  stg_in[g].ta_mag[i] = pa[64:30];
                  stg_in[g].tb_mag[i] = pb[64:30];
               end
            end
         end else begin : g_vel
            always_comb begin
               logic               neg_a;
               logic               neg_b;
               logic signed [36:0] ta;
               logic signed [36:0] tb;
               stg_in[g] = stg_ff[g-1];
               for (int i = 0; i < 3; i++) begin
                  neg_a = stg_ff[g-1].d_neg ^ stg_ff[g-1].p_neg[i];
                  neg_b = ~stg_ff[g-1].d_neg ^ stg_ff[g-1].p_neg[i];
                  ta = neg_a ? -$signed({2'b0, stg_ff[g-1].ta_mag[i]})
                             : $signed({2'b0, stg_ff[g-1].ta_mag[i]});
                  tb = neg_b ? -$signed({2'b0, stg_ff[g-1].tb_mag[i]})
                             : $signed({2'b0, stg_ff[g-1].tb_mag[i]});
                  stg_in[g].nva[i] = epcr_pkg::sat_s(37'($signed(stg_ff[g-1].va[i])) + ta);
                  stg_in[g].nvb[i] = epcr_pkg::sat_s(37'($signed(stg_ff[g-1].vb[i])) + tb);
               end
               // no mass at all: leave both bodies as they were
               if (stg_ff[g-1].zero_mass) begin
                  stg_in[g].move_a = '0;
                  stg_in[g].move_b = '0;
                  stg_in[g].nva = stg_ff[g-1].va;
                  stg_in[g].nvb = stg_ff[g-1].vb;
               end
            end
         end
      end
   endgenerate

   assign tail_live = vld_ff[N_STAGES-1] && stg_ff[N_STAGES-1].emit;
   assign buf_free  = !buf_vld_ff || (sel_ff == epcr_pkg::BODY_B && rsp_ch.ready);
   assign adv       = !tail_live || buf_free;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N_STAGES-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff <= stg_in;
      end
   end

   always_comb begin
      load_a.which_body = epcr_pkg::BODY_A;
      load_a.move_x     = stg_ff[N_STAGES-1].move_a[0];
      load_a.move_y     = stg_ff[N_STAGES-1].move_a[1];
      load_a.move_z     = stg_ff[N_STAGES-1].move_a[2];
      load_a.new_vel_x  = stg_ff[N_STAGES-1].nva[0];
      load_a.new_vel_y  = stg_ff[N_STAGES-1].nva[1];
      load_a.new_vel_z  = stg_ff[N_STAGES-1].nva[2];
      load_a.zero_mass  = stg_ff[N_STAGES-1].zero_mass;
      load_b.which_body = epcr_pkg::BODY_B;
      load_b.move_x     = stg_ff[N_STAGES-1].move_b[0];
      load_b.move_y     = stg_ff[N_STAGES-1].move_b[1];
      load_b.move_z     = stg_ff[N_STAGES-1].move_b[2];
      load_b.new_vel_x  = stg_ff[N_STAGES-1].nvb[0];
      load_b.new_vel_y  = stg_ff[N_STAGES-1].nvb[1];
      load_b.new_vel_z  = stg_ff[N_STAGES-1].nvb[2];
      load_b.zero_mass  = stg_ff[N_STAGES-1].zero_mass;
   end

   // pair buffer: shows the body A word, then the body B word
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         sel_ff     <= epcr_pkg::BODY_A;
      end else if (tail_live && buf_free) begin
         buf_vld_ff <= 1'b1;
         sel_ff     <= epcr_pkg::BODY_A;
      end else if (buf_vld_ff && rsp_ch.ready) begin
         if (sel_ff == epcr_pkg::BODY_A) begin
            sel_ff <= epcr_pkg::BODY_B;
         end else begin
            buf_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail_live && buf_free) begin
         buf_a_ff <= load_a;
         buf_b_ff <= load_b;
      end
   end

   assign rsp_ch.valid = buf_vld_ff;
   assign rsp_ch.data  = (sel_ff == epcr_pkg::BODY_B) ? buf_b_ff : buf_a_ff;

endmodule

>>> rtl/epcr_checker.sv
`timescale 1ns / 1ps
// port checker for the elastic pair collision block, with its bind
module epcr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_which_body,
   input logic rsp_zero_mass
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_which_body) &&
                                  $stable(rsp_zero_mass))
      else $error("response word dropped or changed while stalled");

   a_b_follows_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_which_body == epcr_pkg::BODY_A |=>
         rsp_valid && rsp_which_body == epcr_pkg::BODY_B)
      else $error("body B word did not follow body A word");

   a_pair_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_which_body == epcr_pkg::BODY_A |=>
         rsp_zero_mass == $past(rsp_zero_mass))
      else $error("zero mass flag differs within a pair");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind elastic_pair_collision_response epcr_checker u_epcr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_which_body (rsp_ch.data.which_body),
   .rsp_zero_mass  (rsp_ch.data.zero_mass)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the elastic pair collision response block
module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;

   epcr_req_if req_ch ();
   epcr_rsp_if rsp_ch ();

   elastic_pair_collision_response dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   epcr_pkg::rsp_word_type pending_words[$];

   typedef struct {
      epcr_pkg::req_word_type pair;
      logic                   fixed;
      epcr_pkg::rsp_word_type word_a;
      epcr_pkg::rsp_word_type word_b;
   } stim_row_type;

   task automatic report(input string what, input epcr_pkg::rsp_word_type got,
                         input epcr_pkg::rsp_word_type exp);
      $display("error %0s: got %h expected %h", what, got, exp);
      fail_count++;
   endtask

   function automatic longint sat_long(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint abs_long(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // truncating x*f/2^sh with sign of x
   function automatic longint scale_trunc(input longint x, input longint unsigned f,
                                          input int sh);
      longint unsigned m, hi, lo, r;
      longint s;
      m = abs_long(x);
      hi = (m >> 32) * f;
      lo = (m & 64'hFFFF_FFFF) * f;
      r = (hi << (32 - sh)) + (lo >> sh);
      s = longint'(r & 64'h7FFF_FFFF_FFFF_FFFF);
      return x < 0 ? -s : s;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic epcr_pkg::rsp_word_type make_word(input logic body, input longint mv[3],
                                                        input longint vl[3], input logic zm);
      epcr_pkg::rsp_word_type w;
      w.which_body = body;
      w.move_x = 32'(sat_long(mv[0]));
      w.move_y = 32'(sat_long(mv[1]));
      w.move_z = 32'(sat_long(mv[2]));
      w.new_vel_x = 32'(sat_long(vl[0]));
      w.new_vel_y = 32'(sat_long(vl[1]));
      w.new_vel_z = 32'(sat_long(vl[2]));
      w.zero_mass = zm;
      return w;
   endfunction

   // predicts the body A and body B words of one pair; returns 0 on a zero push
   function automatic bit resolve_pair(input epcr_pkg::req_word_type q,
                                       output epcr_pkg::rsp_word_type wa,
                                       output epcr_pkg::rsp_word_type wb);
      longint p[3], va[3], vb[3], u[3], mva[3], mvb[3], na[3], nb[3], zero3[3];
      longint unsigned total, fa, fb, sq, len, m;
      longint da, db, ca, cb, ka, kb, uc, ta, tb;
      p = '{longint'(q.push_x), longint'(q.push_y), longint'(q.push_z)};
      va = '{longint'(q.vel_a_x), longint'(q.vel_a_y), longint'(q.vel_a_z)};
      vb = '{longint'(q.vel_b_x), longint'(q.vel_b_y), longint'(q.vel_b_z)};
      zero3 = '{0, 0, 0};
      if (p[0] == 0 && p[1] == 0 && p[2] == 0) return 1'b0;
      total = longint'(q.mass_a) + longint'(q.mass_b);
      if (total == 0) begin
         wa = make_word(epcr_pkg::BODY_A, zero3, va, 1'b1);
         wb = make_word(epcr_pkg::BODY_B, zero3, vb, 1'b1);
         return 1'b1;
      end
      fa = (longint'(q.mass_a) << 31) / total;
      fb = (64'd1 << 31) - fa;
      sq = 0;
      for (int i = 0; i < 3; i++) sq += abs_long(p[i]) * abs_long(p[i]);
      len = int_root(sq);
      if (len == 0) len = 1;
      da = 0;
      db = 0;
      for (int i = 0; i < 3; i++) begin
         m = abs_long(p[i]);
         u[i] = longint'((m << 30) / len);
         mva[i] = -longint'((m * fb) >> 31);
         mvb[i] = longint'((m * fa) >> 31);
         if (p[i] < 0) begin
            u[i] = -u[i];
            mva[i] = -mva[i];
            mvb[i] = -mvb[i];
         end
         da += u[i] * va[i];
         db += u[i] * vb[i];
      end
      ca = da / (64'sd1 << 30);
      cb = db / (64'sd1 << 30);
      ka = scale_trunc(cb - ca, fb, 30);
      kb = scale_trunc(ca - cb, fa, 30);
      for (int i = 0; i < 3; i++) begin
         uc = abs_long(u[i]);
         ta = scale_trunc(ka, uc, 30);
         tb = scale_trunc(kb, uc, 30);
         if (u[i] < 0) begin
            ta = -ta;
            tb = -tb;
         end
         na[i] = va[i] + ta;
         nb[i] = vb[i] + tb;
      end
      wa = make_word(epcr_pkg::BODY_A, mva, na, 1'b0);
      wb = make_word(epcr_pkg::BODY_B, mvb, nb, 1'b0);
      return 1'b1;
   endfunction

   function automatic logic [31:0] pick32(input int kind);
      case (kind)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(signed'($urandom_range(0, 65535)) - 32768);
         3: return 32'($urandom_range(0, 1 << 20)) << $urandom_range(0, 8);
         default: return $urandom();
      endcase
   endfunction

   function automatic epcr_pkg::req_word_type random_pair();
      epcr_pkg::req_word_type q;
      q.push_x = pick32($urandom_range(0, 6));
      q.push_y = pick32($urandom_range(0, 6));
      q.push_z = pick32($urandom_range(0, 6));
      q.mass_a = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
      q.mass_b = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
      if ($urandom_range(0, 2) == 0) q.mass_b = q.mass_b >> $urandom_range(0, 31);
      q.vel_a_x = pick32($urandom_range(0, 6));
      q.vel_a_y = pick32($urandom_range(0, 6));
      q.vel_a_z = pick32($urandom_range(0, 6));
      q.vel_b_x = pick32($urandom_range(0, 6));
      q.vel_b_y = pick32($urandom_range(0, 6));
      q.vel_b_z = pick32($urandom_range(0, 6));
      if ($urandom_range(0, 29) == 0) begin
         q.push_x = 0;
         q.push_y = 0;
         q.push_z = 0;
      end
      return q;
   endfunction

   // valid stays high after the word is taken; idle pauses and the caller drop it
   task automatic send_pair(input epcr_pkg::req_word_type q);
      epcr_pkg::rsp_word_type wa, wb;
      while ($urandom_range(1, 100) <= idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= q;
      do @(posedge clock); while (!req_ch.ready);
      if (resolve_pair(q, wa, wb)) begin
         pending_words = {pending_words, wa, wb};
      end
   endtask

   // response side: stall, check against the oldest expected word
   always @(posedge clock) begin
      epcr_pkg::rsp_word_type exp;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_words.size() == 0) begin
               report("unexpected word", rsp_ch.data, '0);
            end else begin
               exp = pending_words.pop_front();
               if (rsp_ch.data !== exp) report("word", rsp_ch.data, exp);
            end
         end
         rsp_ch.ready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   initial begin
      #4_000_000;
      $display("elastic_pair_collision_response: mismatch");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      epcr_pkg::req_word_type q;
      epcr_pkg::rsp_word_type wa, wb;
      int n;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero push gives nothing
      r = '{pair: '0, fixed: 1'b0, word_a: '0, word_b: '0};
      rows = {rows, r};
      // zero total mass: no move, velocities passed through
      r.pair = '0;
      r.pair.push_x = 32'h0001_0000;
      r.pair.vel_a_x = 32'h7FFF_FFFF;
      r.pair.vel_a_y = 32'h8000_0000;
      r.pair.vel_b_z = 32'h8000_0000;
      r.fixed = 1'b1;
      r.word_a = '{epcr_pkg::BODY_A, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1};
      r.word_b = '{epcr_pkg::BODY_B, 0, 0, 0, 0, 0, 32'h8000_0000, 1'b1};
      rows = {rows, r};
      // negated full-scale push, all weight on A then all on B: the A move saturates
      r.pair = '0;
      r.pair.push_x = 32'h8000_0000;
      r.pair.mass_a = 32'hFFFF_FFFF;
      r.fixed = 1'b0;
      rows = {rows, r};
      r.pair.mass_a = 0;
      r.pair.mass_b = 32'hFFFF_FFFF;
      rows = {rows, r};
      // equal masses head on along x
      r.pair = '0;
      r.pair.push_x = 32'h0001_0000;
      r.pair.mass_a = 32'h1000;
      r.pair.mass_b = 32'h1000;
      r.pair.vel_a_x = 32'h0001_0000;
      r.pair.vel_b_x = 32'hFFFF_0000;
      rows = {rows, r};
      for (int k = 0; k < 16; k++) begin
         r.pair = '0;
         r.pair.push_x = (k & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         r.pair.push_y = (k & 2) ? 32'h7FFF_FFFF : 32'h0000_0001;
         r.pair.push_z = (k & 4) ? 32'h8000_0000 : 32'h0000_0000;
         r.pair.mass_a = (k & 8) ? 32'hFFFF_FFFF : 32'h0000_0001;
         r.pair.mass_b = 32'hFFFF_FFFF >> k;
         r.pair.vel_a_x = (k & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         r.pair.vel_a_y = 32'h7FFF_FFFF;
         r.pair.vel_a_z = 32'h8000_0000;
         r.pair.vel_b_x = (k & 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
         r.pair.vel_b_y = 32'h8000_0000;
         r.pair.vel_b_z = 32'h7FFF_FFFF;
         rows = {rows, r};
      end

      foreach (rows[i]) begin
         if (rows[i].fixed) begin
            void'(resolve_pair(rows[i].pair, wa, wb));
            if (wa !== rows[i].word_a) report("table A", wa, rows[i].word_a);
            if (wb !== rows[i].word_b) report("table B", wb, rows[i].word_b);
         end
         send_pair(rows[i].pair);
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 86; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 86; end
            3: begin idle_pct = 24; stall_pct = 24; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         n = (ph == 4) ? 330 : 400;
         for (int i = 0; i < n; i++) begin
            q = random_pair();
            send_pair(q);
            // hold off until the pipeline has drained
            if (ph == 3 && i == 200) begin
               req_ch.valid <= 1'b0;
               wait (pending_words.size() == 0);
               @(posedge clock);
            end
         end
      end

      req_ch.valid <= 1'b0;
      wait (pending_words.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("elastic_pair_collision_response: match");
      end else begin
         $display("elastic_pair_collision_response: mismatch");
      end
      $finish;
   end
endmodule
